// File: sv/wbpp_pkg.sv
// Shared types, constants and helper functions of the wildcard byte pattern patcher.
// No dependencies; every other file of the block imports this package.
package wbpp_pkg;

    localparam int WIN_DEPTH       = 16;
    localparam int MAX_SIG_LEN_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int LEN_W       = 5;
    localparam int MASK_W      = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_OFF_W   = 32;
    localparam int OUT_TDATA_W = 40;
    localparam int FILL_W      = 4;

    typedef logic [WIN_DEPTH-1:0][7:0] win_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIG_LO   = 3'd0,
        CFG_SIG_HI   = 3'd1,
        CFG_SIG_CARE = 3'd2,
        CFG_SIG_LEN  = 3'd3,
        CFG_REP_LO   = 3'd4,
        CFG_REP_HI   = 3'd5,
        CFG_REP_MASK = 3'd6
    } cfg_idx_t;

    // One result beat as it sits in the output buffer.
    typedef struct packed {
        logic [OUT_OFF_W-1:0] offset;
        logic                 found;
        logic                 last;
        logic [7:0]           data;
    } out_beat_t;

    // Reverses the byte order of a 16-byte vector.
    function automatic logic [8*WIN_DEPTH-1:0] rev_bytes(input logic [8*WIN_DEPTH-1:0] v);
        logic [8*WIN_DEPTH-1:0] r;
        for (int j = 0; j < WIN_DEPTH; j++) begin
            r[8*j +: 8] = v[8*(WIN_DEPTH-1-j) +: 8];
        end
        return r;
    endfunction

    // Reverses the bit order of a 16-bit mask.
    function automatic logic [MASK_W-1:0] rev_bits(input logic [MASK_W-1:0] v);
        logic [MASK_W-1:0] r;
        for (int j = 0; j < MASK_W; j++) begin
            r[j] = v[MASK_W-1-j];
        end
        return r;
    endfunction

endpackage

// File: sv/wildcard_byte_pattern_patcher_core.sv
// Top level of the wildcard byte pattern patcher: window, stream state, config registers.
// Depends on wbpp_pkg, wbpp_match and wbpp_out_buf.
//
//   Channel   Direction  Beat contents (lowest bit first)
//   s_*       in         tdata: in_byte[7:0]; tlast: in_last
//   m_*       out        tdata: out_byte[7:0], match_offset[39:8]; tlast: out_last;
//                        tuser: match_found
//   cfg_*     in         write enable, register index, 64-bit write data
//
// The compare and patch of the whole window sit between the window register and the
// output buffer, so bytes stream at one per cycle while s_tready is high.
// A byte that fills the window to 16 pushes the oldest byte out as one beat.
// A last byte starts a flush of fill+1 beats (up to 16, moved from the window register into
// the output buffer one per cycle while it is not full); s_tready is low for the whole flush.
// The two-entry output buffer lets input continue while one result waits; when both
// entries are taken, s_tready drops until the sink takes a beat.
// Reset is synchronous and active low; the window store itself is not cleared, as only
// entries that were written are ever read.
module wildcard_byte_pattern_patcher_core #(
    parameter int MAX_SIG_LEN = wbpp_pkg::MAX_SIG_LEN_DEF,
    parameter int OFFSET_BITS = wbpp_pkg::OFFSET_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input stream. s_tdata: in_byte[7:0].
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [wbpp_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                               s_tlast,
    // Result stream. m_tdata: out_byte[7:0], match_offset[39:8]. m_tuser: match_found.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [wbpp_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                               m_tlast,
    output logic                               m_tuser,
    // Configuration write port.
    input  logic                               cfg_wr_en,
    input  logic [wbpp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wbpp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import wbpp_pkg::*;

    // Configuration registers.
    logic [CFG_DATA_W-1:0]  sig_lo_reg, sig_hi_reg, rep_lo_reg, rep_hi_reg;
    logic [MASK_W-1:0]      care_reg, wmask_reg;
    logic [LEN_W-1:0]       len_reg;

    // Stream state. The window holds the newest byte in entry 0.
    win_t                   win_reg;
    logic [FILL_W-1:0]      fill_reg;
    logic [OFFSET_BITS-1:0] pos_reg;
    logic                   found_reg;
    logic [OFFSET_BITS-1:0] off_reg;
    logic                   drain_reg;
    logic [FILL_W-1:0]      drain_idx_reg;

    logic                   in_acc;
    win_t                   win_app;
    win_t                   win_pat;
    logic [LEN_W-1:0]       fill_app;
    logic                   hit;
    logic [OFFSET_BITS-1:0] len_m1;
    logic [OFFSET_BITS-1:0] start_off;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [OFFSET_BITS-1:0] off_sel;
    logic [OUT_OFF_W-1:0]   off_sat;
    logic                   norm_push;
    logic                   push;
    logic                   buf_full;
    out_beat_t              push_beat;
    out_beat_t              head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_lo_reg <= '0;
            sig_hi_reg <= '0;
            care_reg   <= '0;
            len_reg    <= '0;
            rep_lo_reg <= '0;
            rep_hi_reg <= '0;
            wmask_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_SIG_LO:   sig_lo_reg <= cfg_wdata;
                CFG_SIG_HI:   sig_hi_reg <= cfg_wdata;
                CFG_SIG_CARE: care_reg   <= cfg_wdata[MASK_W-1:0];
                CFG_SIG_LEN:  len_reg    <= cfg_wdata[LEN_W-1:0];
                CFG_REP_LO:   rep_lo_reg <= cfg_wdata;
                CFG_REP_HI:   rep_hi_reg <= cfg_wdata;
                CFG_REP_MASK: wmask_reg  <= cfg_wdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // No bytes are taken during a flush or while the output buffer is full.
    assign s_tready = !drain_reg && !buf_full;
    assign in_acc   = s_tvalid && s_tready;

    // The incoming byte enters lane 0 and the rest of the window moves up one lane.
    always_comb begin
        win_app[0] = s_tdata;
        for (int k = 1; k < WIN_DEPTH; k++) begin
            win_app[k] = win_reg[k-1];
        end
    end
    assign fill_app = {1'b0, fill_reg} + LEN_W'(1);

    wbpp_match #(
        .MAX_SIG_LEN (MAX_SIG_LEN)
    ) u_match (
        .win_in    (win_app),
        .fill_cnt  (fill_app),
        .found     (found_reg),
        .sig_bytes ({sig_hi_reg, sig_lo_reg}),
        .sig_care  (care_reg),
        .sig_len   (len_reg),
        .rep_bytes ({rep_hi_reg, rep_lo_reg}),
        .rep_mask  (wmask_reg),
        .win_out   (win_pat),
        .hit       (hit)
    );

    // The match starts len-1 bytes before the newest byte; the position saturates.
    assign len_m1    = OFFSET_BITS'(len_reg - LEN_W'(1));
    assign start_off = (pos_reg >= len_m1) ? (pos_reg - len_m1) : '0;
    assign pos_inc   = (pos_reg == '1) ? pos_reg : (pos_reg + OFFSET_BITS'(1));

    // Outside a flush the offset shown is the one in force after this byte.
    assign off_sel = (!drain_reg && hit) ? start_off : off_reg;

    if (OFFSET_BITS > OUT_OFF_W) begin : g_off_sat
        assign off_sat = (|off_sel[OFFSET_BITS-1:OUT_OFF_W]) ? '1 : off_sel[OUT_OFF_W-1:0];
    end else begin : g_off_ext
        assign off_sat = OUT_OFF_W'(off_sel);
    end

    // A byte that fills all 16 lanes, and is not last, pushes out the oldest lane.
    assign norm_push = in_acc && !s_tlast && (fill_reg == FILL_W'(WIN_DEPTH - 1));
    assign push      = norm_push || (drain_reg && !buf_full);

    always_comb begin
        push_beat.offset = off_sat;
        if (drain_reg) begin
            push_beat.data  = win_reg[drain_idx_reg];
            push_beat.last  = (drain_idx_reg == '0);
            push_beat.found = found_reg;
        end else begin
            push_beat.data  = win_pat[WIN_DEPTH-1];
            push_beat.last  = 1'b0;
            push_beat.found = found_reg || hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            off_reg       <= '0;
            drain_reg     <= 1'b0;
            drain_idx_reg <= '0;
        end else if (drain_reg) begin
            // Flush oldest first; the match flag and offset clear with the final beat.
            if (!buf_full) begin
                drain_idx_reg <= drain_idx_reg - FILL_W'(1);
                if (drain_idx_reg == '0) begin
                    drain_reg <= 1'b0;
                    found_reg <= 1'b0;
                    off_reg   <= '0;
                end
            end
        end else if (in_acc) begin
            if (hit) begin
                found_reg <= 1'b1;
                off_reg   <= start_off;
            end
            if (s_tlast) begin
                fill_reg      <= '0;
                pos_reg       <= '0;
                drain_reg     <= 1'b1;
                drain_idx_reg <= fill_reg;
            end else begin
                pos_reg <= pos_inc;
                if (fill_reg != FILL_W'(WIN_DEPTH - 1)) begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            win_reg <= win_pat;
        end
    end

    wbpp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_beat (push_beat),
        .full      (buf_full),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .head      (head)
    );

    assign m_tdata = {head.offset, head.data};
    assign m_tlast = head.last;
    assign m_tuser = head.found;

endmodule

// File: sv/wbpp_match.sv
// Signature compare and in-place patch over the window, newest byte in lane 0.
// Depends on wbpp_pkg.
module wbpp_match #(
    parameter int MAX_SIG_LEN = wbpp_pkg::MAX_SIG_LEN_DEF
) (
    input  wbpp_pkg::win_t                          win_in,
    input  logic [wbpp_pkg::LEN_W-1:0]              fill_cnt,
    input  logic                                    found,
    input  logic [2*wbpp_pkg::CFG_DATA_W-1:0]       sig_bytes,
    input  logic [wbpp_pkg::MASK_W-1:0]             sig_care,
    input  logic [wbpp_pkg::LEN_W-1:0]              sig_len,
    input  logic [2*wbpp_pkg::CFG_DATA_W-1:0]       rep_bytes,
    input  logic [wbpp_pkg::MASK_W-1:0]             rep_mask,
    output wbpp_pkg::win_t                          win_out,
    output logic                                    hit
);
    import wbpp_pkg::*;

    logic                        enable;
    logic [LEN_W-1:0]            shamt;
    logic [8*WIN_DEPTH-1:0]      sig_al;
    logic [8*WIN_DEPTH-1:0]      rep_al;
    logic [MASK_W-1:0]           care_al;
    logic [MASK_W-1:0]           wr_al;
    logic [WIN_DEPTH-1:0]        lane_ok;

    // Lane k holds the k-th newest byte, which lines up with signature byte
    // len-1-k. Reversing the signature and shifting it down by 16-len bytes
    // puts that byte in lane k and zeros (no care, no write) beyond len.
    assign enable  = !found && (sig_len != '0) && (sig_len <= LEN_W'(MAX_SIG_LEN))
                     && (sig_len <= fill_cnt);
    assign shamt   = LEN_W'(WIN_DEPTH) - sig_len;
    assign sig_al  = rev_bytes(sig_bytes) >> {shamt, 3'b000};
    assign rep_al  = rev_bytes(rep_bytes) >> {shamt, 3'b000};
    assign care_al = rev_bits(sig_care) >> shamt;
    assign wr_al   = rev_bits(rep_mask) >> shamt;

    assign hit = enable && (&lane_ok);

    for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_lane
        if (k < MAX_SIG_LEN) begin : g_cmp
            assign lane_ok[k] = !care_al[k] || (win_in[k] == sig_al[8*k +: 8]);
            assign win_out[k] = (hit && wr_al[k]) ? rep_al[8*k +: 8] : win_in[k];
        end else begin : g_pass
            assign lane_ok[k] = 1'b1;
            assign win_out[k] = win_in[k];
        end
    end

endmodule

// File: sv/wbpp_out_buf.sv
// Two-entry output buffer that decouples the result channel from the input side.
// Depends on wbpp_pkg.
module wbpp_out_buf (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  wbpp_pkg::out_beat_t   push_beat,
    output logic                  full,
    output logic                  m_valid,
    input  logic                  m_ready,
    output wbpp_pkg::out_beat_t   head
);
    import wbpp_pkg::*;

    out_beat_t   slot0_reg, slot0_next;
    out_beat_t   slot1_reg, slot1_next;
    logic [1:0]  count_reg, count_next;
    logic        pop;
    logic [1:0]  wr_pos;

    assign m_valid = (count_reg != 2'd0);
    assign full    = (count_reg == 2'd2);
    assign head    = slot0_reg;
    assign pop     = m_valid && m_ready;
    assign wr_pos  = count_reg - {1'b0, pop};

    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (pop) begin
            slot0_next = slot1_reg;
        end
        if (push) begin
            if (wr_pos == 2'd0) begin
                slot0_next = push_beat;
            end else begin
                slot1_next = push_beat;
            end
        end
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

// File: sv/wbpp_checker.sv
// Port-level checks of the wildcard byte pattern patcher, bound to its top level.
// Depends on wbpp_pkg and wildcard_byte_pattern_patcher_core.
module wbpp_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              s_tlast,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [wbpp_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic                              m_tlast,
    input logic                              m_tuser
);
    import wbpp_pkg::*;

    logic                  seen_reg;
    logic [OUT_OFF_W-1:0]  seen_off_reg;

    // Remembers that a beat of the current stream already reported a match.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            seen_reg <= m_tuser && !m_tlast;
        end
        if (m_tvalid && m_tready) begin
            seen_off_reg <= m_tdata[OUT_TDATA_W-1:IN_TDATA_W];
        end
    end

    // A waiting result beat holds still.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Nothing is shown on the result side right after reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Without a match the offset reads zero.
    a_off_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[OUT_TDATA_W-1:IN_TDATA_W] == '0)
        else $error("nonzero offset without a match");

    // Once reported, a match and its offset stay until the stream ends.
    a_match_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && seen_reg |-> m_tuser && m_tdata[OUT_TDATA_W-1:IN_TDATA_W] == seen_off_reg)
        else $error("match report changed within a stream");

    // A last input byte starts a flush, so the next cycle takes no byte.
    a_flush_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("byte taken right after a last byte");

endmodule

bind wildcard_byte_pattern_patcher_core wbpp_checker u_wbpp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
